FILE: sv/fenwick_point_set_range_sum_assert.svh
// Assertion macros for the Fenwick range-sum block.
// Depends on nothing; included by the checker file.
`ifndef FENWICK_POINT_SET_RANGE_SUM_ASSERT_SVH
`define FENWICK_POINT_SET_RANGE_SUM_ASSERT_SVH

// Condition a implies condition c in the same cycle.
`define FPS_ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("same-cycle assertion failed");

// Condition a implies condition c in the next cycle.
`define FPS_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle assertion failed");

`endif

FILE: sv/fps_pkg.sv
// Shared constants for the Fenwick range-sum block.
// Depends on nothing; imported by the controller, top level and checker.
`default_nettype none

package fps_pkg;

	localparam int IDX_W        = 11;
	localparam int VAL_W        = 64;
	localparam int SIZE_DEFAULT = 1024;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

endpackage

`default_nettype wire

FILE: sv/fps_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
// Depends on nothing.
`default_nettype none

module fps_ram #(
	parameter int DEPTH = 1025,
	parameter int AW    = 11,
	parameter int DW    = 64
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/fps_ctrl.sv
// Sequencer that walks the Fenwick chains through the two memories.
// Depends on fps_pkg.
`default_nettype none

module fps_ctrl #(
	parameter int SIZE = fps_pkg::SIZE_DEFAULT,
	parameter int PW   = $clog2(SIZE + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       operation,
	input  wire logic [fps_pkg::IDX_W-1:0]  index,
	input  wire logic [fps_pkg::VAL_W-1:0]  new_value,
	input  wire logic [fps_pkg::IDX_W-1:0]  start_index,
	input  wire logic [fps_pkg::IDX_W-1:0]  end_index,
	output logic                            result_valid,
	output logic [fps_pkg::VAL_W-1:0]       range_sum,
	output logic                            psum_we,
	output logic [PW-1:0]                   psum_waddr,
	output logic [fps_pkg::VAL_W-1:0]       psum_wdata,
	output logic                            psum_re,
	output logic [PW-1:0]                   psum_raddr,
	input  wire logic [fps_pkg::VAL_W-1:0]  psum_rdata,
	output logic                            plain_we,
	output logic [PW-1:0]                   plain_waddr,
	output logic [fps_pkg::VAL_W-1:0]       plain_wdata,
	output logic                            plain_re,
	output logic [PW-1:0]                   plain_raddr,
	input  wire logic [fps_pkg::VAL_W-1:0]  plain_rdata
);

	import fps_pkg::*;

	localparam int CW = PW + 1;
	localparam int EW = (IDX_W > CW) ? IDX_W : CW;
	localparam logic [EW-1:0] SIZE_E = EW'(SIZE);
	localparam logic [CW-1:0] SIZE_C = CW'(SIZE);
	localparam logic [PW-1:0] LAST_A = PW'(SIZE);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_READ,
		ST_A_DELTA,
		ST_A_ADD,
		ST_Q_LOAD,
		ST_Q_ACC
	} state_t;

	state_t            state_q;
	logic [PW-1:0]     clr_q;
	logic [PW-1:0]     idx_q;
	logic [VAL_W-1:0]  val_q;
	logic [VAL_W-1:0]  delta_q;
	logic [VAL_W-1:0]  acc_q;
	logic [PW-1:0]     sb_q;
	logic [PW-1:0]     eb_q;
	logic [CW-1:0]     pos_q;
	logic              phase_q;

	logic [EW-1:0]     idx_ext;
	logic [EW-1:0]     first_ext;
	logic [EW-1:0]     last_ext;
	logic [EW-1:0]     below_ext;
	logic              idx_ok;
	logic [PW-1:0]     eb_sat;
	logic [PW-1:0]     sb_sat;
	logic [CW-1:0]     lowbit;
	logic [CW-1:0]     climb_nxt;
	logic [CW-1:0]     fall_nxt;
	logic [PW-1:0]     load_pos;
	logic [VAL_W-1:0]  acc_nxt;

	assign idx_ext   = EW'(index);
	assign first_ext = EW'(start_index);
	assign last_ext  = EW'(end_index);
	assign below_ext = (first_ext == '0) ? '0 : first_ext - EW'(1);
	assign idx_ok    = (idx_ext != '0) && (idx_ext <= SIZE_E);
	assign eb_sat    = (last_ext > SIZE_E) ? LAST_A : PW'(last_ext);
	assign sb_sat    = (below_ext > SIZE_E) ? LAST_A : PW'(below_ext);

	assign lowbit    = pos_q & (~pos_q + CW'(1));
	assign climb_nxt = pos_q + lowbit;
	assign fall_nxt  = pos_q & (pos_q - CW'(1));
	assign load_pos  = phase_q ? sb_q : eb_q;
	assign acc_nxt   = phase_q ? acc_q - psum_rdata : acc_q + psum_rdata;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		psum_we     = 1'b0;
		psum_waddr  = '0;
		psum_wdata  = '0;
		psum_re     = 1'b0;
		psum_raddr  = '0;
		plain_we    = 1'b0;
		plain_waddr = '0;
		plain_wdata = '0;
		plain_re    = 1'b0;
		plain_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				psum_we     = 1'b1;
				psum_waddr  = clr_q;
				plain_we    = 1'b1;
				plain_waddr = clr_q;
			end
			ST_IDLE: begin
			end
			ST_A_READ: begin
				plain_re    = 1'b1;
				plain_raddr = idx_q;
			end
			ST_A_DELTA: begin
				plain_we    = 1'b1;
				plain_waddr = idx_q;
				plain_wdata = val_q;
				psum_re     = 1'b1;
				psum_raddr  = idx_q;
			end
			ST_A_ADD: begin
				psum_we    = 1'b1;
				psum_waddr = pos_q[PW-1:0];
				psum_wdata = psum_rdata + delta_q;
				if (climb_nxt <= SIZE_C) begin
					psum_re    = 1'b1;
					psum_raddr = climb_nxt[PW-1:0];
				end
			end
			ST_Q_LOAD: begin
				if (load_pos != '0) begin
					psum_re    = 1'b1;
					psum_raddr = load_pos;
				end
			end
			ST_Q_ACC: begin
				if (fall_nxt != '0) begin
					psum_re    = 1'b1;
					psum_raddr = fall_nxt[PW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			phase_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (operation == OP_ASSIGN) begin
							idx_q <= PW'(idx_ext);
							val_q <= new_value;
							if (idx_ok) begin
								state_q <= ST_A_READ;
							end
						end else begin
							eb_q    <= eb_sat;
							sb_q    <= sb_sat;
							phase_q <= 1'b0;
							acc_q   <= '0;
							state_q <= ST_Q_LOAD;
						end
					end
				end
				ST_A_READ: begin
					state_q <= ST_A_DELTA;
				end
				ST_A_DELTA: begin
					delta_q <= val_q - plain_rdata;
					pos_q   <= CW'(idx_q);
					state_q <= ST_A_ADD;
				end
				ST_A_ADD: begin
					pos_q <= climb_nxt;
					if (climb_nxt > SIZE_C) begin
						state_q <= ST_IDLE;
					end
				end
				ST_Q_LOAD: begin
					pos_q <= CW'(load_pos);
					if (load_pos != '0) begin
						state_q <= ST_Q_ACC;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						range_sum    <= acc_q;
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_Q_ACC: begin
					acc_q <= acc_nxt;
					pos_q <= fall_nxt;
					if (fall_nxt == '0) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= ST_Q_LOAD;
						end else begin
							range_sum    <= acc_nxt;
							result_valid <= 1'b1;
							state_q      <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/fenwick_point_set_range_sum.sv
// Top level of the Fenwick point-assign, range-sum block.
// Depends on fps_pkg, fps_ctrl and fps_ram.
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      operation, index, new_value,
//                                                start_index, end_index
// result    out        result_valid, one cycle   range_sum
//
// After reset busy stays high while both memories are cleared.
// An assign reads the old value, forms the delta and updates each entry on its
// climbing chain (at most log2(SIZE)+1); an out-of-range index is accepted and
// ignored. A query reads one entry per set bit of the end bound and of start-1.
// The walks are set by the single read port of the partial-sum memory.
// The result strobe rises as busy falls; the receiver cannot stall it.
`default_nettype none

module fenwick_point_set_range_sum #(
	parameter int SIZE = fps_pkg::SIZE_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             operation,
	input  wire logic        [fps_pkg::IDX_W-1:0] index,
	input  wire logic signed [fps_pkg::VAL_W-1:0] new_value,
	input  wire logic        [fps_pkg::IDX_W-1:0] start_index,
	input  wire logic        [fps_pkg::IDX_W-1:0] end_index,
	output logic                                  result_valid,
	output logic signed      [fps_pkg::VAL_W-1:0] range_sum
);

	import fps_pkg::*;

	localparam int PW = $clog2(SIZE + 1);

	logic              psum_we;
	logic [PW-1:0]     psum_waddr;
	logic [VAL_W-1:0]  psum_wdata;
	logic              psum_re;
	logic [PW-1:0]     psum_raddr;
	logic [VAL_W-1:0]  psum_rdata;
	logic              plain_we;
	logic [PW-1:0]     plain_waddr;
	logic [VAL_W-1:0]  plain_wdata;
	logic              plain_re;
	logic [PW-1:0]     plain_raddr;
	logic [VAL_W-1:0]  plain_rdata;
	logic [VAL_W-1:0]  sum_raw;

	fps_ctrl #(
		.SIZE (SIZE),
		.PW   (PW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.index        (index),
		.new_value    (new_value),
		.start_index  (start_index),
		.end_index    (end_index),
		.result_valid (result_valid),
		.range_sum    (sum_raw),
		.psum_we      (psum_we),
		.psum_waddr   (psum_waddr),
		.psum_wdata   (psum_wdata),
		.psum_re      (psum_re),
		.psum_raddr   (psum_raddr),
		.psum_rdata   (psum_rdata),
		.plain_we     (plain_we),
		.plain_waddr  (plain_waddr),
		.plain_wdata  (plain_wdata),
		.plain_re     (plain_re),
		.plain_raddr  (plain_raddr),
		.plain_rdata  (plain_rdata)
	);

	assign range_sum = signed'(sum_raw);

	fps_ram #(
		.DEPTH (SIZE + 1),
		.AW    (PW),
		.DW    (VAL_W)
	) u_psum_ram (
		.clk   (clk),
		.we    (psum_we),
		.waddr (psum_waddr),
		.wdata (psum_wdata),
		.re    (psum_re),
		.raddr (psum_raddr),
		.rdata (psum_rdata)
	);

	fps_ram #(
		.DEPTH (SIZE + 1),
		.AW    (PW),
		.DW    (VAL_W)
	) u_plain_ram (
		.clk   (clk),
		.we    (plain_we),
		.waddr (plain_waddr),
		.wdata (plain_wdata),
		.re    (plain_re),
		.raddr (plain_raddr),
		.rdata (plain_rdata)
	);

endmodule

`default_nettype wire

FILE: sv/fps_checker.sv
// Port-level checker for the Fenwick range-sum block, bound to the top level.
// Depends on fps_pkg and fenwick_point_set_range_sum_assert.svh.
`default_nettype none

`include "fenwick_point_set_range_sum_assert.svh"

module fps_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic operation,
	input wire logic result_valid
);

	import fps_pkg::*;

	logic query_xfer;
	logic assign_xfer;

	assign query_xfer  = start && !busy && (operation == OP_QUERY);
	assign assign_xfer = start && !busy && (operation == OP_ASSIGN);

	`FPS_ASSERT_NEXT(a_query_goes_busy, clk, arst_n, query_xfer, busy)
	`FPS_ASSERT_NEXT(a_assign_no_result, clk, arst_n, assign_xfer, !result_valid)
	`FPS_ASSERT_SAME(a_result_ends_busy, clk, arst_n, result_valid, !busy && $past(busy))
	`FPS_ASSERT_NEXT(a_single_strobe, clk, arst_n, result_valid, !result_valid)

endmodule

bind fenwick_point_set_range_sum fps_checker u_fps_checker (.*);

`default_nettype wire
